@@ hdl/mlp_pkg.sv @@
// shared types, constants and tables for the mlp inference block
`default_nettype none
package mlp_pkg;
    localparam int MaxLayers = 8;
    localparam int MaxWidth  = 64;
    localparam int DataBits  = 16;
    localparam int LayBits   = $clog2(MaxLayers);
    localparam int IdxBits   = $clog2(MaxWidth);
    localparam int WAddrBits = LayBits + 2 * IdxBits;
    localparam int BAddrBits = LayBits + IdxBits;

    localparam logic [1:0] OpWeight  = 2'd0;
    localparam logic [1:0] OpBias    = 2'd1;
    localparam logic [1:0] OpFeature = 2'd2;

    localparam logic [2:0] ActSigmoid = 3'd0;
    localparam logic [2:0] ActTanh    = 3'd1;
    localparam logic [2:0] ActRelu    = 3'd2;
    localparam logic [2:0] ActSoftmax = 3'd4;

    localparam logic [2:0] RegHidAct = 3'd0;
    localparam logic [2:0] RegOutAct = 3'd1;
    localparam logic [2:0] RegLayers = 3'd2;
    localparam logic [2:0] RegInW    = 3'd3;
    localparam logic [2:0] RegHidW   = 3'd4;
    localparam logic [2:0] RegOutW   = 3'd5;

    function automatic logic [16:0] sig_tab(input logic [4:0] i);
        case (i)
            5'd0: sig_tab = 17'd2048;  5'd1: sig_tab = 17'd2550;
            5'd2: sig_tab = 17'd2994;  5'd3: sig_tab = 17'd3349;
            5'd4: sig_tab = 17'd3608;  5'd5: sig_tab = 17'd3785;
            5'd6: sig_tab = 17'd3902;  5'd7: sig_tab = 17'd3976;
            5'd8: sig_tab = 17'd4022;  5'd9: sig_tab = 17'd4051;
            5'd10: sig_tab = 17'd4069; 5'd11: sig_tab = 17'd4079;
            5'd12: sig_tab = 17'd4086; 5'd13: sig_tab = 17'd4090;
            5'd14: sig_tab = 17'd4092; 5'd15: sig_tab = 17'd4094;
            default: sig_tab = 17'd4095;
        endcase
    endfunction

    function automatic logic [16:0] tanh_tab(input logic [4:0] i);
        case (i)
            5'd0: tanh_tab = 17'd0;    5'd1: tanh_tab = 17'd1893;
            5'd2: tanh_tab = 17'd3119; 5'd3: tanh_tab = 17'd3707;
            5'd4: tanh_tab = 17'd3949; 5'd5: tanh_tab = 17'd4041;
            5'd6: tanh_tab = 17'd4076; 5'd7: tanh_tab = 17'd4089;
            5'd8: tanh_tab = 17'd4093; 5'd9: tanh_tab = 17'd4095;
            default: tanh_tab = 17'd4096;
        endcase
    endfunction

    function automatic logic [16:0] exp_tab(input logic [4:0] i);
        case (i)
            5'd0: exp_tab = 17'd65536; 5'd1: exp_tab = 17'd39750;
            5'd2: exp_tab = 17'd24109; 5'd3: exp_tab = 17'd14623;
            5'd4: exp_tab = 17'd8869;  5'd5: exp_tab = 17'd5380;
            5'd6: exp_tab = 17'd3263;  5'd7: exp_tab = 17'd1979;
            5'd8: exp_tab = 17'd1200;  5'd9: exp_tab = 17'd728;
            5'd10: exp_tab = 17'd442;  5'd11: exp_tab = 17'd268;
            5'd12: exp_tab = 17'd162;  5'd13: exp_tab = 17'd99;
            5'd14: exp_tab = 17'd60;   5'd15: exp_tab = 17'd36;
            default: exp_tab = 17'd22;
        endcase
    endfunction

    // table interpolation, kind 0 sigmoid, 1 tanh, 2 exp; mag below 16*2048
    function automatic logic [16:0] interp(input logic [1:0] kind,
                                           input logic [14:0] mag);
        logic [4:0] i;
        logic signed [17:0] a, b, d;
        logic signed [29:0] p;
        i = {1'b0, mag[14:11]};
        case (kind)
            2'd0: begin
                a = signed'({1'b0, sig_tab(i)}); b = signed'({1'b0, sig_tab(i + 5'd1)});
            end
            2'd1: begin
                a = signed'({1'b0, tanh_tab(i)}); b = signed'({1'b0, tanh_tab(i + 5'd1)});
            end
            default: begin
                a = signed'({1'b0, exp_tab(i)}); b = signed'({1'b0, exp_tab(i + 5'd1)});
            end
        endcase
        d = b - a;
        p = d * signed'({1'b0, mag[10:0]}) + 30'sd1024;
        interp = 17'(a + 18'(p >>> 11));
    endfunction

    function automatic logic signed [15:0] activate(input logic signed [15:0] x,
                                                   input logic [2:0] code);
        logic [16:0] mag;
        logic [16:0] y;
        mag = x[15] ? 17'(-{x[15], x}) : 17'({1'b0, x});
        case (code)
            ActSigmoid: begin
                y = (mag[16:15] != 2'b00) ? 17'd4095 : interp(2'd0, mag[14:0]);
                activate = x[15] ? 16'(17'd4096 - y) : 16'(y);
            end
            ActTanh: begin
                y = (mag[16:15] != 2'b00) ? 17'd4096 : interp(2'd1, mag[14:0]);
                activate = x[15] ? 16'(-y) : 16'(y);
            end
            ActRelu: activate = x[15] ? 16'sd0 : x;
            default: activate = x;
        endcase
    endfunction

    typedef struct packed {
        logic [1:0] hid_act;
        logic [2:0] out_act;
        logic [3:0] layers;
        logic [6:0] in_w;
        logic [6:0] hid_w;
        logic [6:0] out_w;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [16:0]      dividend;
        logic [31:0]      divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [16:0] quot;
    } div_rsp_t;
endpackage
`default_nettype wire

@@ hdl/mlp_div.sv @@
// shift-subtract divider for softmax normalization, one quotient bit per cycle
`default_nettype none
module mlp_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mlp_pkg::div_req_t req,
    output mlp_pkg::div_rsp_t      rsp
);
    logic [28:0] num_reg;     // e*4096 + s/2 fits in 29 bits
    logic [32:0] rem_reg;
    logic [28:0] q_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [32:0] trial;

    assign trial = {rem_reg[31:0], num_reg[28]} - {1'b0, req.divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                num_reg  <= {req.dividend, 12'd0} + 29'(req.divisor >> 1);
                rem_reg  <= '0;
                q_reg    <= '0;
                cnt_reg  <= 5'd0;
            end else if (busy_reg) begin
                num_reg <= {num_reg[27:0], 1'b0};
                if (!trial[32]) begin
                    rem_reg <= trial;
                    q_reg   <= {q_reg[27:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[31:0], num_reg[28]};
                    q_reg   <= {q_reg[27:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd28) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient never exceeds 4096
    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = q_reg[16:0];
endmodule
`default_nettype wire

@@ hdl/mlp_mac.sv @@
// shared multiply-accumulate unit with saturation and requantization
`default_nettype none
module mlp_mac (
    input  wire logic               aclk,
    input  wire logic               clr,
    input  wire logic               add_en,
    input  wire logic signed [15:0] w,
    input  wire logic signed [15:0] x,
    input  wire logic               bias_en,
    input  wire logic signed [15:0] bias,
    output logic signed [15:0]      z
);
    logic signed [31:0] prod_reg;
    logic signed [31:0] acc_reg;
    logic signed [32:0] sum;
    logic signed [32:0] rnd;

    always_comb begin
        if (bias_en) sum = 33'(acc_reg) + 33'(signed'({bias, 12'd0}));
        else         sum = 33'(acc_reg) + 33'(prod_reg);
        rnd = 33'(acc_reg) + 33'sd2048;
        // floor of rnd / 4096 saturated to 16 bits
        if (rnd > 33'sd134217727)       z = 16'sd32767;
        else if (rnd < -33'sd134217728) z = -16'sd32768;
        else                            z = rnd[27:12];
    end

    always_ff @(posedge aclk) begin
        prod_reg <= w * x;
        if (clr) acc_reg <= '0;
        else if (add_en || bias_en) begin
            if (sum > 33'sd2147483647)        acc_reg <= 32'sh7fffffff;
            else if (sum < -33'sd2147483648)  acc_reg <= 32'sh80000000;
            else                              acc_reg <= sum[31:0];
        end
    end
endmodule
`default_nettype wire

@@ hdl/mlp_forward_inference_top.sv @@
// top level of the mlp forward inference block: stores, sequencer and output
`default_nettype none
// channel  | ports                          | payload
// input    | s_axis_tvalid/tready/tdata/tlast | tdata: operation, layer_index, neuron_index,
//          |                                  |   source_index, value; tlast: last_feature
// result   | m_axis_tvalid/tready/tdata/tlast | tdata: output_index, output_value;
//          |                                  |   tlast: last_output
// config   | cfg_we/cfg_addr/cfg_wdata        | register index and value
//
// loads are taken while idle; a last feature starts a pass through the
// single mac unit, layer by layer, then the results are sent in order;
// softmax adds two scans over the outputs (maximum, then exp and sum)
// and a divider run per result.
// reset is synchronous active low and clears control state and config registers only.
// the result register holds while m_axis_tready is low; no input is taken
// while a pass runs, only the last result of a sample may still wait.
module mlp_forward_inference_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // operation, layer_index, neuron_index, source_index, value
    input  wire logic        s_axis_tlast,  // last_feature
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // output_index, output_value, zero fill
    output logic             m_axis_tlast,  // last_output
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [6:0]  cfg_wdata
);
    typedef enum logic [3:0] {
        S_IDLE, S_MAC_RD, S_MAC, S_BIAS, S_BIAS2, S_WB, S_MAX, S_EXP, S_DIV_GO,
        S_DIV_WAIT, S_OUT_RD, S_OUT
    } state_t;

    mlp_pkg::cfg_t cfg_reg;
    state_t state_reg;

    logic signed [15:0] wmem [2**mlp_pkg::WAddrBits];
    logic signed [15:0] bmem [2**mlp_pkg::BAddrBits];
    logic signed [15:0] fmem [mlp_pkg::MaxWidth];
    logic signed [15:0] amem [2*mlp_pkg::MaxWidth];
    logic [31:0]        emem [mlp_pkg::MaxWidth];

    logic [1:0]  op;
    logic [2:0]  lay_in;
    logic [5:0]  neu_in, src_in;
    logic signed [15:0] val_in;
    assign op     = s_axis_tdata[1:0];
    assign lay_in = s_axis_tdata[4:2];
    assign neu_in = s_axis_tdata[10:5];
    assign src_in = s_axis_tdata[16:11];
    assign val_in = s_axis_tdata[32:17];

    logic s_acc;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_acc = s_axis_tvalid && s_axis_tready;

    // clamped sizes
    logic [3:0] nl;
    logic [6:0] nin0, nhid, nout;
    always_comb begin
        nl   = (cfg_reg.layers < 4'd2) ? 4'd2 : (cfg_reg.layers > 4'd8 ? 4'd8 : cfg_reg.layers);
        nin0 = (cfg_reg.in_w == 7'd0) ? 7'd1 : (cfg_reg.in_w > 7'd64 ? 7'd64 : cfg_reg.in_w);
        nhid = (cfg_reg.hid_w == 7'd0) ? 7'd1 : (cfg_reg.hid_w > 7'd64 ? 7'd64 : cfg_reg.hid_w);
        nout = (cfg_reg.out_w == 7'd0) ? 7'd1 : (cfg_reg.out_w > 7'd64 ? 7'd64 : cfg_reg.out_w);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{hid_act: mlp_pkg::ActTanh[1:0], out_act: mlp_pkg::ActSoftmax,
                         layers: 4'd2, in_w: 7'd1, hid_w: 7'd1, out_w: 7'd1};
        end else if (cfg_we) begin
            case (cfg_addr)
                mlp_pkg::RegHidAct: cfg_reg.hid_act <= cfg_wdata[1:0];
                mlp_pkg::RegOutAct: cfg_reg.out_act <= cfg_wdata[2:0];
                mlp_pkg::RegLayers: cfg_reg.layers  <= cfg_wdata[3:0];
                mlp_pkg::RegInW:    cfg_reg.in_w    <= cfg_wdata;
                mlp_pkg::RegHidW:   cfg_reg.hid_w   <= cfg_wdata;
                mlp_pkg::RegOutW:   cfg_reg.out_w   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer counters
    logic [2:0] l_reg;
    logic [5:0] i_reg, j_reg;
    logic [6:0] nin_reg, ncur_reg;
    logic       last_layer;
    logic       rd_ok_reg, bias_rd_reg;
    logic signed [15:0] w_rd_reg, x_rd_reg, b_rd_reg, a_rd_reg;
    logic signed [15:0] m_reg;
    logic [31:0] sum_reg;
    logic [31:0] e_rd_reg;
    logic signed [15:0] res_reg;
    logic [5:0]  oidx_reg;
    logic        olast_reg, mvalid_reg;
    logic        mac_clr, mac_add, mac_bias;
    logic signed [15:0] z;
    logic signed [15:0] zact;
    mlp_pkg::div_req_t dreq;
    mlp_pkg::div_rsp_t drsp;

    assign last_layer = ({1'b0, l_reg} == nl - 4'd1);

    mlp_mac u_mac (
        .aclk(aclk), .clr(mac_clr), .add_en(mac_add), .w(w_rd_reg), .x(x_rd_reg),
        .bias_en(mac_bias), .bias(b_rd_reg), .z(z)
    );

    mlp_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    assign zact = last_layer ? z : mlp_pkg::activate(z, {1'b0, cfg_reg.hid_act});
    assign mac_clr  = (state_reg == S_MAC_RD);
    assign mac_bias = (state_reg == S_BIAS2);

    // pipeline: read regs -> product reg -> accumulate
    logic rd_v_reg, prod_v_reg;
    assign mac_add = prod_v_reg;

    // softmax helpers
    logic signed [16:0] diff;
    logic [16:0] ev;
    assign diff = 17'(m_reg) - 17'(a_rd_reg);
    assign ev = diff[16:15] != 2'b00 ? 17'd0 : mlp_pkg::interp(2'd2, diff[14:0]);

    logic softmax;
    assign softmax = (cfg_reg.out_act == mlp_pkg::ActSoftmax);
    logic [5:0] fin_idx;
    assign fin_idx = 6'(nout - 7'd1);

    always_ff @(posedge aclk) begin
        // memories: one write port each
        if (s_acc && op == mlp_pkg::OpWeight)
            wmem[{lay_in, neu_in, src_in}] <= val_in;
        if (s_acc && op == mlp_pkg::OpBias)
            bmem[{lay_in, neu_in}] <= val_in;
        if (s_acc && op == mlp_pkg::OpFeature)
            fmem[neu_in] <= val_in;
        if (state_reg == S_WB)
            amem[{l_reg[0], i_reg}] <= zact;
        if (state_reg == S_EXP && rd_ok_reg)
            emem[j_reg - 6'd1] <= 32'(ev);
        // registered reads
        w_rd_reg <= wmem[{l_reg, i_reg, j_reg}];
        x_rd_reg <= (l_reg == 3'd0) ? fmem[j_reg] : amem[{~l_reg[0], j_reg}];
        b_rd_reg <= bmem[{l_reg, i_reg}];
        a_rd_reg <= amem[{l_reg[0], j_reg}];
        e_rd_reg <= emem[j_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
            dreq.start <= 1'b0;
        end else begin
            dreq.start <= 1'b0;
            prod_v_reg <= rd_v_reg;
            rd_v_reg   <= 1'b0;
            if (mvalid_reg && m_axis_tready) mvalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_acc && op == mlp_pkg::OpFeature && s_axis_tlast) begin
                        l_reg    <= 3'd0;
                        i_reg    <= 6'd0;
                        j_reg    <= 6'd0;
                        nin_reg  <= nin0;
                        ncur_reg <= (nl == 4'd1) ? nout : nhid;
                        state_reg <= S_MAC_RD;
                    end
                end
                S_MAC_RD: begin
                    j_reg <= 6'd0;
                    state_reg <= S_MAC;
                end
                S_MAC: begin
                    rd_v_reg <= 1'b1;
                    if ({1'b0, j_reg} == nin_reg - 7'd1) state_reg <= S_BIAS;
                    else j_reg <= j_reg + 6'd1;
                end
                S_BIAS: begin
                    // wait for the last product to drain
                    if (!rd_v_reg && !prod_v_reg) state_reg <= S_BIAS2;
                end
                S_BIAS2: state_reg <= S_WB;
                S_WB: begin
                    if ({1'b0, i_reg} == ncur_reg - 7'd1) begin
                        if (last_layer) begin
                            j_reg <= 6'd0;
                            rd_ok_reg <= 1'b0;
                            state_reg <= softmax ? S_MAX : S_OUT_RD;
                        end else begin
                            l_reg    <= l_reg + 3'd1;
                            nin_reg  <= ncur_reg;
                            ncur_reg <= ({1'b0, l_reg} + 4'd2 == nl) ? nout : nhid;
                            i_reg    <= 6'd0;
                            state_reg <= S_MAC_RD;
                        end
                    end else begin
                        i_reg <= i_reg + 6'd1;
                        state_reg <= S_MAC_RD;
                    end
                end
                S_MAX: begin
                    // a_rd_reg holds the entry j addressed in the previous cycle, j wraps to zero after a full layer
                    rd_ok_reg <= 1'b1;
                    if (rd_ok_reg && ($signed(a_rd_reg) > m_reg || j_reg == 6'd1))
                        m_reg <= a_rd_reg;
                    if (!rd_ok_reg) j_reg <= j_reg + 6'd1;
                    else if ((j_reg - 6'd1) == fin_idx) begin
                        j_reg <= 6'd0;
                        rd_ok_reg <= 1'b0;
                        sum_reg <= '0;
                        state_reg <= S_EXP;
                    end else j_reg <= j_reg + 6'd1;
                end
                S_EXP: begin
                    rd_ok_reg <= 1'b1;
                    if (rd_ok_reg) sum_reg <= sum_reg + 32'(ev);
                    if (rd_ok_reg && (j_reg - 6'd1) == fin_idx) begin
                        j_reg <= 6'd0;
                        state_reg <= S_OUT_RD;
                    end else j_reg <= j_reg + 6'd1;
                end
                S_OUT_RD: begin
                    if (!mvalid_reg || m_axis_tready) state_reg <= softmax ? S_DIV_GO : S_OUT;
                end
                S_DIV_GO: begin
                    dreq.start    <= 1'b1;
                    dreq.dividend <= e_rd_reg[16:0];
                    dreq.divisor  <= sum_reg;
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (drsp.done) state_reg <= S_OUT;
                end
                S_OUT: begin
                    mvalid_reg <= 1'b1;
                    res_reg    <= softmax ? 16'(drsp.quot)
                                          : mlp_pkg::activate(a_rd_reg, cfg_reg.out_act);
                    oidx_reg   <= j_reg;
                    olast_reg  <= (j_reg == fin_idx);
                    if (j_reg == fin_idx) state_reg <= S_IDLE;
                    else begin
                        j_reg <= j_reg + 6'd1;
                        state_reg <= S_OUT_RD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // out_act 3 and codes above softmax act as identity via the activate default arm
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = {2'b00, res_reg, oidx_reg};
    assign m_axis_tlast  = olast_reg;

    // no input taken while a pass runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> state_reg == S_IDLE)
        else $error("input ready outside idle");
    // divider only runs in softmax states
    assert property (@(posedge aclk) disable iff (!aresetn)
        drsp.busy |-> (state_reg == S_DIV_WAIT))
        else $error("divider busy outside wait");
    // a pending result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
endmodule
`default_nettype wire
